>>> rtl/bev_pkg.sv
package bev_pkg;

   // Default sizes of the block.
   localparam int NUM_BUTTONS_DEF = 3;
   localparam int COUNT_BITS_DEF  = 16;

   // Configuration registers.
   localparam int CFG_BITS     = 16;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] REG_REPEAT_THRESHOLD     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_REPEAT_INTERVAL      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_LONG_PRESS_THRESHOLD = 2'd2;

   localparam logic [CFG_BITS-1:0] RST_REPEAT_THRESHOLD     = 16'd20;
   localparam logic [CFG_BITS-1:0] RST_REPEAT_INTERVAL      = 16'd4;
   localparam logic [CFG_BITS-1:0] RST_LONG_PRESS_THRESHOLD = 16'd40;

   // Input word opcodes.
   localparam logic OP_SCAN   = 1'b0;
   localparam logic OP_IGNORE = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_DIV,
      ST_RECORD,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic step;
      logic div_step;
      logic record;
      logic next_btn;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_scan;
      logic repeat_check;
      logic div_last;
      logic last_btn;
      logic pending;
   } status_type;

endpackage

>>> rtl/bev_div.sv
module bev_div #(
   parameter int DVD_BITS = 16,
   parameter int DVS_BITS = 16
) (
   input  logic                clock,
   input  logic                start,
   input  logic                step,
   input  logic [DVD_BITS-1:0] dividend,
   input  logic [DVS_BITS-1:0] divisor,
   output logic                last_step,
   output logic                rem_zero
);

   localparam int CNT_BITS = (DVD_BITS > 1) ? $clog2(DVD_BITS) : 1;

   logic [DVD_BITS-1:0] dvd_ff, dvd_in;
   logic [DVS_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DVS_BITS:0]   shifted;
   logic [DVS_BITS:0]   trial;

   // One restoring step: bring in the next dividend bit and subtract if it fits.
   always_comb begin
      shifted = {rem_ff, dvd_ff[DVD_BITS-1]};
      trial   = shifted - {1'b0, divisor};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         cnt_in = '0;
      end else if (step) begin
         dvd_in = {dvd_ff[DVD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (!trial[DVS_BITS]) begin
            rem_in = trial[DVS_BITS-1:0];
         end else begin
            rem_in = shifted[DVS_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign last_step = (cnt_ff == CNT_BITS'(DVD_BITS - 1));
   assign rem_zero  = (rem_ff == '0);

endmodule

>>> rtl/bev_ctrl.sv
module bev_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                csr_ready,
   input  bev_pkg::status_type status,
   output bev_pkg::cmd_type    cmd
);

   import bev_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.is_scan) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            state_in = status.repeat_check ? ST_DIV : ST_RECORD;
         end
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_RECORD;
            end
         end
         ST_RECORD: begin
            state_in = status.last_btn ? ST_EMIT : ST_STEP;
         end
         ST_EMIT: begin
            if (!status.pending) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_stall    = 1'b1;
      csr_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            csr_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_RECORD: begin
            cmd.record   = 1'b1;
            cmd.next_btn = !status.last_btn;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> rtl/bev_dpath.sv
module bev_dpath #(
   parameter int NUM_BUTTONS = bev_pkg::NUM_BUTTONS_DEF,
   parameter int COUNT_BITS  = bev_pkg::COUNT_BITS_DEF,
   parameter int ID_BITS     = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_opcode,
   input  logic [NUM_BUTTONS-1:0]            req_pressed_levels,
   input  logic [NUM_BUTTONS-1:0]            req_ignore_mask,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [bev_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bev_pkg::CFG_BITS-1:0]      csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ID_BITS-1:0]                rsp_button_id,
   output logic                              rsp_is_press,
   output logic                              rsp_is_release,
   output logic                              rsp_is_repeat,
   output logic                              rsp_is_long_press,
   output logic                              rsp_last_event,
   input  bev_pkg::cmd_type                  cmd,
   output bev_pkg::status_type               status
);

   import bev_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

   // Configuration registers.
   logic [CFG_BITS-1:0] thr_ff, intv_ff, lpt_ff;

   // Per-button state.
   logic [NUM_BUTTONS-1:0] held_ff, held_in;
   logic [NUM_BUTTONS-1:0] ign_ff, ign_in;
   logic [COUNT_BITS-1:0]  count_ff [NUM_BUTTONS];
   logic [COUNT_BITS-1:0]  count_in [NUM_BUTTONS];

   // Pending events of the current tick, one slot per kind and button.
   logic [NUM_BUTTONS-1:0] pr_ff, pr_in;
   logic [NUM_BUTTONS-1:0] press_ff, press_in;
   logic [NUM_BUTTONS-1:0] rep_ff, rep_in;
   logic [NUM_BUTTONS-1:0] lng_ff, lng_in;

   // Tick in progress.
   logic [NUM_BUTTONS-1:0] levels_ff;
   logic [ID_BITS-1:0]     idx_ff;
   logic                   elig_ff;
   logic                   long_hit_ff;

   // Output register.
   logic                   rsp_valid_ff;
   logic [ID_BITS-1:0]     rsp_id_ff;
   logic                   rsp_press_ff, rsp_release_ff, rsp_repeat_ff, rsp_long_ff, rsp_last_ff;

   // Current button values.
   logic                   cur_now, cur_held;
   logic [COUNT_BITS-1:0]  cur_cnt, cnt_new;
   logic [CMP_BITS-1:0]    cnt_ext, thr_ext, lpt_ext, excess;
   logic                   elig, long_hit;
   logic [COUNT_BITS-1:0]  dividend;
   logic                   div_last, rem_zero;

   // Event selection.
   logic [ID_BITS-1:0]     sel_b;
   logic [NUM_BUTTONS-1:0] sel_hot, pr_clr, rep_clr, lng_clr, remaining;
   logic                   pending, out_free, emit_load, sel_last;

   // Hold count update and threshold checks for the current button.
   always_comb begin
      cur_now  = levels_ff[idx_ff];
      cur_held = held_ff[idx_ff];
      cur_cnt  = count_ff[idx_ff];
      cnt_new  = cur_now ? cur_cnt + 1'b1 : '0;
      cnt_ext  = CMP_BITS'(cnt_new);
      thr_ext  = CMP_BITS'(thr_ff);
      lpt_ext  = CMP_BITS'(lpt_ff);
      excess   = cnt_ext - thr_ext;
      elig     = (intv_ff != '0) && (cnt_ext > thr_ext);
      long_hit = (cnt_ext == lpt_ext);
      dividend = excess[COUNT_BITS-1:0];
   end

   // Remainder of the excess count by the repeat interval.
   bev_div #(
      .DVD_BITS (COUNT_BITS),
      .DVS_BITS (CFG_BITS)
   ) u_div (
      .clock     (clock),
      .start     (cmd.step),
      .step      (cmd.div_step),
      .dividend  (dividend),
      .divisor   (intv_ff),
      .last_step (div_last),
      .rem_zero  (rem_zero)
   );

   // Pick the lowest button with a pending event, then the first kind within it.
   always_comb begin
      sel_b = '0;
      for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
         if (pr_ff[b] || rep_ff[b] || lng_ff[b]) begin
            sel_b = ID_BITS'(b);
         end
      end
      sel_hot = NUM_BUTTONS'(1) << sel_b;
      pr_clr  = '0;
      rep_clr = '0;
      lng_clr = '0;
      if (pr_ff[sel_b]) begin
         pr_clr = sel_hot;
      end else if (rep_ff[sel_b]) begin
         rep_clr = sel_hot;
      end else begin
         lng_clr = sel_hot;
      end
      remaining = (pr_ff & ~pr_clr) | (rep_ff & ~rep_clr) | (lng_ff & ~lng_clr);
      sel_last  = ~|remaining;
      pending   = |(pr_ff | rep_ff | lng_ff);
      out_free  = !rsp_valid_ff || !rsp_stall;
      emit_load = cmd.emit && pending && out_free;
   end

   // Next values of the per-button state and the event slots.
   always_comb begin
      held_in  = held_ff;
      ign_in   = ign_ff;
      count_in = count_ff;
      pr_in    = pr_ff;
      press_in = press_ff;
      rep_in   = rep_ff;
      lng_in   = lng_ff;
      if (cmd.accept && (req_opcode == OP_IGNORE)) begin
         ign_in = ign_ff | req_ignore_mask;
      end
      if (cmd.step) begin
         held_in[idx_ff]  = cur_now;
         count_in[idx_ff] = cnt_new;
         if (cur_now != cur_held) begin
            if (cur_now) begin
               pr_in[idx_ff]    = 1'b1;
               press_in[idx_ff] = 1'b1;
               ign_in[idx_ff]   = 1'b0;
            end else if (!ign_ff[idx_ff]) begin
               pr_in[idx_ff]    = 1'b1;
               press_in[idx_ff] = 1'b0;
            end
         end
      end
      if (cmd.record && !ign_ff[idx_ff]) begin
         rep_in[idx_ff] = elig_ff && rem_zero;
         lng_in[idx_ff] = long_hit_ff;
      end
      if (emit_load) begin
         pr_in  = pr_ff & ~pr_clr;
         rep_in = rep_ff & ~rep_clr;
         lng_in = lng_ff & ~lng_clr;
      end
   end

   // Button state and event slots.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         ign_ff  <= '0;
         pr_ff   <= '0;
         rep_ff  <= '0;
         lng_ff  <= '0;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            count_ff[b] <= '0;
         end
      end else begin
         held_ff  <= held_in;
         ign_ff   <= ign_in;
         count_ff <= count_in;
         pr_ff    <= pr_in;
         rep_ff   <= rep_in;
         lng_ff   <= lng_in;
      end
   end

   // Press or release direction of each slot needs no reset.
   always_ff @(posedge clock) begin
      press_ff <= press_in;
   end

   // Tick sequencing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.accept) begin
         idx_ff <= '0;
      end else if (cmd.next_btn) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         levels_ff <= req_pressed_levels;
      end
      if (cmd.step) begin
         elig_ff     <= elig;
         long_hit_ff <= long_hit;
      end
   end

   // Configuration registers; an unknown index is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= RST_REPEAT_THRESHOLD;
         intv_ff <= RST_REPEAT_INTERVAL;
         lpt_ff  <= RST_LONG_PRESS_THRESHOLD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_REPEAT_THRESHOLD:     thr_ff  <= csr_wdata;
            REG_REPEAT_INTERVAL:      intv_ff <= csr_wdata;
            REG_LONG_PRESS_THRESHOLD: lpt_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_id_ff      <= sel_b;
         rsp_press_ff   <= (pr_clr != '0) && press_ff[sel_b];
         rsp_release_ff <= (pr_clr != '0) && !press_ff[sel_b];
         rsp_repeat_ff  <= (rep_clr != '0);
         rsp_long_ff    <= (lng_clr != '0);
         rsp_last_ff    <= sel_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_button_id     = rsp_id_ff;
   assign rsp_is_press      = rsp_press_ff;
   assign rsp_is_release    = rsp_release_ff;
   assign rsp_is_repeat     = rsp_repeat_ff;
   assign rsp_is_long_press = rsp_long_ff;
   assign rsp_last_event    = rsp_last_ff;

   // Status to the controller.
   always_comb begin
      status.is_scan      = (req_opcode == OP_SCAN);
      status.repeat_check = elig;
      status.div_last     = div_last;
      status.last_btn     = (idx_ff == ID_BITS'(NUM_BUTTONS - 1));
      status.pending      = pending;
   end

`ifndef ASSERT_OFF
   // A released button always has a cleared hold count.
   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_chk
      a_released_zero: assert property (@(posedge clock) disable iff (reset)
         !held_ff[g] |-> (count_ff[g] == '0))
         else $error("Released button has a nonzero hold count.");
   end

   // Each word loaded into the output register consumes exactly one event slot.
   a_emit_one: assert property (@(posedge clock) disable iff (reset)
      emit_load |=> ($countones({pr_ff, rep_ff, lng_ff}) + 1 ==
                     $past($countones({pr_ff, rep_ff, lng_ff}))))
      else $error("Output load did not consume exactly one event.");

   // A new item is taken only after every event of the previous tick has left.
   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !pending)
      else $error("Item accepted while events are still pending.");

   // The output register fills only from an emission load.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit_load))
      else $error("Output word appeared without an emission load.");
`endif

endmodule

>>> rtl/button_event_generator.sv
// Scan tick: the item is accepted, then each button in turn passes a step state, a
// remainder division if it is above the repeat threshold with a nonzero interval,
// and a record state; events then leave as the output register frees, until none is left.
// A set-ignore word is taken in the idle state; one item is worked on at a time.
// Reset (synchronous, active high) releases all buttons, clears hold counts and
// ignore marks, and loads the registers with 20, 4 and 40.
module button_event_generator #(
   parameter int NUM_BUTTONS = bev_pkg::NUM_BUTTONS_DEF,
   parameter int COUNT_BITS  = bev_pkg::COUNT_BITS_DEF,
   parameter int ID_BITS     = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic [NUM_BUTTONS-1:0]           req_pressed_levels,
   input  logic [NUM_BUTTONS-1:0]           req_ignore_mask,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bev_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [bev_pkg::CFG_BITS-1:0]     csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ID_BITS-1:0]               rsp_button_id,
   output logic                             rsp_is_press,
   output logic                             rsp_is_release,
   output logic                             rsp_is_repeat,
   output logic                             rsp_is_long_press,
   output logic                             rsp_last_event
);

   import bev_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   bev_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Button state, registers, remainder unit and output register.
   bev_dpath #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .COUNT_BITS  (COUNT_BITS),
      .ID_BITS     (ID_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_opcode         (req_opcode),
      .req_pressed_levels (req_pressed_levels),
      .req_ignore_mask    (req_ignore_mask),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_button_id      (rsp_button_id),
      .rsp_is_press       (rsp_is_press),
      .rsp_is_release     (rsp_is_release),
      .rsp_is_repeat      (rsp_is_repeat),
      .rsp_is_long_press  (rsp_is_long_press),
      .rsp_last_event     (rsp_last_event),
      .cmd                (cmd),
      .status             (status)
   );

endmodule
